>>> src/m64br_pkg.sv
// Shared types and codes for the MIPS64 branch resolve core.
package m64br_pkg;

    typedef enum logic [4:0] {
        OP_BEQ     = 5'd0,
        OP_BNE     = 5'd1,
        OP_BLEZ    = 5'd2,
        OP_BGTZ    = 5'd3,
        OP_BEQL    = 5'd4,
        OP_BNEL    = 5'd5,
        OP_BLEZL   = 5'd6,
        OP_BGTZL   = 5'd7,
        OP_BLTZ    = 5'd8,
        OP_BGEZ    = 5'd9,
        OP_BLTZL   = 5'd10,
        OP_BGEZL   = 5'd11,
        OP_BGEZAL  = 5'd12,
        OP_BGEZALL = 5'd13,
        OP_J       = 5'd14,
        OP_JAL     = 5'd15,
        OP_JR      = 5'd16,
        OP_JALR    = 5'd17
    } t_op;

    typedef enum logic [2:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LEZ = 3'd2,
        COND_GTZ = 3'd3,
        COND_LTZ = 3'd4,
        COND_GEZ = 3'd5
    } t_cond;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_REL  = 2'd1,
        CLS_JUMP = 2'd2,
        CLS_JREG = 2'd3
    } t_cls;

    localparam logic [4:0]  RA_REG   = 5'd31;
    localparam logic [31:0] LINK_INC = 32'd4;

    typedef struct packed {
        logic [4:0]         opcode;
        logic [63:0]        delay_slot_pc;
        logic signed [63:0] rs_value;
        logic signed [63:0] rt_value;
        logic [15:0]        immediate;
        logic [25:0]        jump_index;
        logic [4:0]         link_dest;
    } t_cmd;

    typedef struct packed {
        logic        taken;
        logic [63:0] target_address;
        logic        nullify_slot;
        logic        link_write;
        logic [4:0]  link_reg;
        logic [63:0] link_value;
        logic        address_error;
    } t_res;

    // decode stage to execute stage
    typedef struct packed {
        t_cls        cls;
        t_cond       cond;
        logic        likely;
        logic        link_write;
        logic [4:0]  link_reg;
        logic        rs_eq_rt;
        logic        rs_neg;
        logic        rs_zero;
        logic        rs_misal;
        logic [63:0] rs;
        logic [31:0] pc_hi;
        logic [3:0]  pc_region_lo;
        logic [31:0] rel_lo;
        logic        rel_carry;
        logic        off_sign;
        logic [31:0] link_lo;
        logic        link_carry;
        logic [25:0] jump_index;
    } t_s1;

    // execute stage to output stage
    typedef struct packed {
        t_cls        cls;
        logic        cond_met;
        logic        likely;
        logic        link_write;
        logic [4:0]  link_reg;
        logic [63:0] rel_target;
        logic [63:0] jump_target;
        logic [63:0] link_addr;
        logic [63:0] rs;
        logic        rs_misal;
    } t_s2;

endpackage

>>> src/m64br_decode.sv
// Stage 1: opcode decode, operand compares and low halves of the address adds.
module m64br_decode import m64br_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_s1  o_s1
);

    logic        r_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [31:0] off_lo;
    logic [32:0] rel_sum;
    logic [32:0] link_sum;

    always_comb begin
        off_lo   = {{14{i_cmd.immediate[15]}}, i_cmd.immediate, 2'b00};
        rel_sum  = {1'b0, i_cmd.delay_slot_pc[31:0]} + {1'b0, off_lo};
        link_sum = {1'b0, i_cmd.delay_slot_pc[31:0]} + {1'b0, LINK_INC};

        n_s1              = '0;
        n_s1.cls          = CLS_REL;
        n_s1.cond         = COND_EQ;
        n_s1.rs_eq_rt     = (i_cmd.rs_value == i_cmd.rt_value);
        n_s1.rs_neg       = i_cmd.rs_value[63];
        n_s1.rs_zero      = (i_cmd.rs_value == '0);
        n_s1.rs_misal     = |i_cmd.rs_value[1:0];
        n_s1.rs           = i_cmd.rs_value;
        n_s1.pc_hi        = i_cmd.delay_slot_pc[63:32];
        n_s1.pc_region_lo = i_cmd.delay_slot_pc[31:28];
        n_s1.rel_lo       = rel_sum[31:0];
        n_s1.rel_carry    = rel_sum[32];
        n_s1.off_sign     = i_cmd.immediate[15];
        n_s1.link_lo      = link_sum[31:0];
        n_s1.link_carry   = link_sum[32];
        n_s1.jump_index   = i_cmd.jump_index;

        case (t_op'(i_cmd.opcode))
            OP_BEQ:     n_s1.cond = COND_EQ;
            OP_BNE:     n_s1.cond = COND_NE;
            OP_BLEZ:    n_s1.cond = COND_LEZ;
            OP_BGTZ:    n_s1.cond = COND_GTZ;
            OP_BEQL: begin
                n_s1.cond   = COND_EQ;
                n_s1.likely = 1'b1;
            end
            OP_BNEL: begin
                n_s1.cond   = COND_NE;
                n_s1.likely = 1'b1;
            end
            OP_BLEZL: begin
                n_s1.cond   = COND_LEZ;
                n_s1.likely = 1'b1;
            end
            OP_BGTZL: begin
                n_s1.cond   = COND_GTZ;
                n_s1.likely = 1'b1;
            end
            OP_BLTZ:    n_s1.cond = COND_LTZ;
            OP_BGEZ:    n_s1.cond = COND_GEZ;
            OP_BLTZL: begin
                n_s1.cond   = COND_LTZ;
                n_s1.likely = 1'b1;
            end
            OP_BGEZL: begin
                n_s1.cond   = COND_GEZ;
                n_s1.likely = 1'b1;
            end
            OP_BGEZAL: begin
                n_s1.cond       = COND_GEZ;
                n_s1.link_write = 1'b1;
                n_s1.link_reg   = RA_REG;
            end
            OP_BGEZALL: begin
                n_s1.cond       = COND_GEZ;
                n_s1.likely     = 1'b1;
                n_s1.link_write = 1'b1;
                n_s1.link_reg   = RA_REG;
            end
            OP_J:       n_s1.cls = CLS_JUMP;
            OP_JAL: begin
                n_s1.cls        = CLS_JUMP;
                n_s1.link_write = 1'b1;
                n_s1.link_reg   = RA_REG;
            end
            OP_JR:      n_s1.cls = CLS_JREG;
            OP_JALR: begin
                n_s1.cls        = CLS_JREG;
                n_s1.link_write = 1'b1;
                n_s1.link_reg   = i_cmd.link_dest;
            end
            default:    n_s1.cls = CLS_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

>>> src/m64br_exec.sv
// Stage 2: condition evaluation, upper halves of the address adds, jump target.
module m64br_exec import m64br_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_s1,
    output logic o_valid,
    output t_s2  o_s2
);

    logic        r_valid;
    t_s2         r_s2;
    t_s2         n_s2;
    logic        cond_met;
    logic [31:0] rel_hi;
    logic [31:0] link_hi;

    always_comb begin
        case (i_s1.cond)
            COND_EQ:  cond_met = i_s1.rs_eq_rt;
            COND_NE:  cond_met = !i_s1.rs_eq_rt;
            COND_LEZ: cond_met = i_s1.rs_neg || i_s1.rs_zero;
            COND_GTZ: cond_met = !i_s1.rs_neg && !i_s1.rs_zero;
            COND_LTZ: cond_met = i_s1.rs_neg;
            COND_GEZ: cond_met = !i_s1.rs_neg;
            default:  cond_met = 1'b0;
        endcase

        rel_hi  = i_s1.pc_hi + {32{i_s1.off_sign}} + {31'd0, i_s1.rel_carry};
        link_hi = i_s1.pc_hi + {31'd0, i_s1.link_carry};

        n_s2.cls         = i_s1.cls;
        n_s2.cond_met    = cond_met;
        n_s2.likely      = i_s1.likely;
        n_s2.link_write  = i_s1.link_write;
        n_s2.link_reg    = i_s1.link_reg;
        n_s2.rel_target  = {rel_hi, i_s1.rel_lo};
        n_s2.jump_target = {i_s1.pc_hi, i_s1.pc_region_lo, i_s1.jump_index, 2'b00};
        n_s2.link_addr   = {link_hi, i_s1.link_lo};
        n_s2.rs          = i_s1.rs;
        n_s2.rs_misal    = i_s1.rs_misal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

>>> src/mips64_branch_resolve_core.sv
// Top level of the MIPS64 branch resolve core: pipeline and result register.
//
// Resolves one MIPS64 branch or jump per transfer. A command is taken on every
// clock edge with start high; busy is always low, so a new command can follow
// in every cycle. Each result appears on o_result, marked by o_done, once its
// command has passed the decode and compare, execute and output register
// stages. Results leave in command order and must be taken when shown,
// the core has no way to hold them.
module mips64_branch_resolve_core import m64br_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_done,
    output t_res o_result
);

    logic s1_valid;
    t_s1  s1;
    logic s2_valid;
    t_s2  s2;
    logic r_done;
    t_res r_result;
    t_res n_result;

    m64br_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_cmd   (i_cmd),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    m64br_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    always_comb begin
        n_result            = '0;
        n_result.link_write = s2.link_write;
        n_result.link_reg   = s2.link_reg;
        n_result.link_value = s2.link_write ? s2.link_addr : '0;
        case (s2.cls)
            CLS_REL: begin
                n_result.taken          = s2.cond_met;
                n_result.target_address = s2.rel_target;
                n_result.nullify_slot   = s2.likely && !s2.cond_met;
            end
            CLS_JUMP: begin
                n_result.taken          = 1'b1;
                n_result.target_address = s2.jump_target;
            end
            CLS_JREG: begin
                n_result.taken          = !s2.rs_misal;
                n_result.target_address = s2.rs;
                n_result.address_error  = s2.rs_misal;
            end
            default: n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
